// ===== sv/psm_pkg.sv =====
// Shared types and constants for the polyphonic sample mixer.
// No dependencies; used by psm_mac and polyphonic_sample_mixer.
`timescale 1ns / 1ps
`default_nettype none

package psm_pkg;

  // Parameter defaults
  localparam int VOICES_DEF    = 12;
  localparam int MEM_DEPTH_DEF = 65536;

  // Field widths fixed by the interface
  localparam int ACT_W    = 2;
  localparam int ADDR_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 17;
  localparam int GAIN_W   = 16;
  localparam int STAT_W   = 2;
  localparam int SLOT_W   = 4;

  // Q2.14 gain: product is shifted down by this much
  localparam int GAIN_SHIFT = 14;
  // Signed sample x unsigned gain (with a zero sign bit)
  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  // Scaled term magnitude stays below 2^17
  localparam int TERM_W = 18;

  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PLAY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP = 2'd2;
  localparam logic [ACT_W-1:0] ACT_TICK = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_VOICE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;  // zero the accumulator
    logic vld;  // sample and gain inputs carry a term this cycle
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/polyphonic_sample_mixer.sv =====
// Polyphonic sample mixer top level: sample memory, voice pool, sequencer
// and output register. Depends on psm_pkg and psm_mac.
`timescale 1ns / 1ps
`default_nettype none

// A pool of VOICES playback voices shares one sample memory of MEMORY_DEPTH
// signed 16-bit words (MEMORY_DEPTH is taken as a power of two; addresses
// wrap on its low bits). Every input transaction yields exactly one result
// transaction. Load writes one word and stop frees every voice. A play with a
// nonzero length scans the voices from index 0 for the lowest free one, one
// voice a cycle. Tick walks all voices through one memory read port and one
// shared multiply-accumulate unit, one voice a cycle, then drains the
// two-stage read/multiply pipeline. The input side is ready only while the
// sequencer is idle; a finished result sits in the output register until
// taken, and the next transaction may be accepted meanwhile, but its own
// result then waits in the sequencer, with the input held off, until the
// output register is free. The sample memory has no reset: reading a word
// never loaded returns whatever it holds.

module polyphonic_sample_mixer #(
  parameter int VOICES       = psm_pkg::VOICES_DEF,
  parameter int MEMORY_DEPTH = psm_pkg::MEM_DEPTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [psm_pkg::ACT_W-1:0]            action_i,
  input  wire logic [psm_pkg::ADDR_W-1:0]           address_i,
  input  wire logic signed [psm_pkg::SAMPLE_W-1:0]  sample_value_i,
  input  wire logic [psm_pkg::LEN_W-1:0]            length_i,
  input  wire logic [psm_pkg::GAIN_W-1:0]           gain_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [psm_pkg::SAMPLE_W-1:0]       mixed_sample_o,
  output logic [psm_pkg::STAT_W-1:0]                status_o,
  output logic [psm_pkg::SLOT_W-1:0]                voice_slot_o
);

  // Widths derived from the parameters
  localparam int AW    = $clog2(MEMORY_DEPTH);
  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW    = $clog2(VOICES + 1);
  localparam int SW    = (CW > psm_pkg::SLOT_W) ? CW : psm_pkg::SLOT_W;
  localparam int LDW   = (AW > psm_pkg::ADDR_W) ? AW : psm_pkg::ADDR_W;
  localparam int RDW   = (AW > psm_pkg::LEN_W + 1) ? AW : psm_pkg::LEN_W + 1;
  localparam int ACC_W = psm_pkg::TERM_W + $clog2(VOICES + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_MIX    = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [VW-1:0] vidx;
  logic          last_voice;

  // Latched play request
  logic [psm_pkg::ADDR_W-1:0] pstart_q, pstart_d;
  logic [psm_pkg::LEN_W-1:0]  plen_q, plen_d;
  logic [psm_pkg::GAIN_W-1:0] pgain_q, pgain_d;

  // Voice pool: each voice register is read only at the sequencer index
  logic [VOICES-1:0]          vactive_q;
  logic [psm_pkg::ADDR_W-1:0] vstart_q [VOICES];
  logic [psm_pkg::LEN_W-1:0]  vlen_q   [VOICES];
  logic [psm_pkg::LEN_W-1:0]  vpos_q   [VOICES];
  logic [psm_pkg::GAIN_W-1:0] vgain_q  [VOICES];

  logic claim, retire, issue, stop_all;

  // Sample memory and its read stage
  logic signed [psm_pkg::SAMPLE_W-1:0] mem_q [MEMORY_DEPTH];
  logic signed [psm_pkg::SAMPLE_W-1:0] rd_data_q;
  logic                                mem_we;
  logic [LDW-1:0]                      ld_addr_ext;
  logic [AW-1:0]                       waddr;
  logic [RDW-1:0]                      rd_addr_ext;
  logic [AW-1:0]                       raddr;
  logic                                s1_valid_q, s1_valid_d;
  logic [psm_pkg::GAIN_W-1:0]          s1_gain_q, s1_gain_d;

  // Multiply-accumulate
  psm_pkg::mac_ctrl_t      mac_ctrl;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_busy;
  logic signed [psm_pkg::SAMPLE_W-1:0] sat_mix;

  // Result staging and output register
  logic signed [psm_pkg::SAMPLE_W-1:0] res_mix_q, res_mix_d;
  logic [psm_pkg::STAT_W-1:0]          res_st_q, res_st_d;
  logic [psm_pkg::SLOT_W-1:0]          res_slot_q, res_slot_d;
  logic                                out_valid_q, out_valid_d;
  logic signed [psm_pkg::SAMPLE_W-1:0] out_mix_q, out_mix_d;
  logic [psm_pkg::STAT_W-1:0]          out_st_q, out_st_d;
  logic [psm_pkg::SLOT_W-1:0]          out_slot_q, out_slot_d;
  logic [SW-1:0]                       slot_ext;

  logic in_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign vidx       = idx_q[VW-1:0];
  assign last_voice = (idx_q == CW'(VOICES - 1));
  assign slot_ext   = SW'(idx_q);

  // Address wrap: keep the low AW bits
  assign ld_addr_ext = LDW'(address_i);
  assign waddr       = ld_addr_ext[AW-1:0];
  assign rd_addr_ext = RDW'(vstart_q[vidx]) + RDW'(vpos_q[vidx]);
  assign raddr       = rd_addr_ext[AW-1:0];

  // Saturate the accumulated mix to 16 bits
  always_comb begin
    if (acc > ACC_W'(psm_pkg::SAT_MAX)) begin
      sat_mix = psm_pkg::SAMPLE_W'(psm_pkg::SAT_MAX);
    end else if (acc < ACC_W'(psm_pkg::SAT_MIN)) begin
      sat_mix = psm_pkg::SAMPLE_W'(psm_pkg::SAT_MIN);
    end else begin
      sat_mix = acc[psm_pkg::SAMPLE_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pstart_d    = pstart_q;
    plen_d      = plen_q;
    pgain_d     = pgain_q;
    res_mix_d   = res_mix_q;
    res_st_d    = res_st_q;
    res_slot_d  = res_slot_q;
    claim       = 1'b0;
    retire      = 1'b0;
    issue       = 1'b0;
    stop_all    = 1'b0;
    mem_we      = 1'b0;
    mac_ctrl    = '0;
    s1_valid_d  = 1'b0;
    s1_gain_d   = vgain_q[vidx];
    out_valid_d = out_valid_q && !out_ready_i;
    out_mix_d   = out_mix_q;
    out_st_d    = out_st_q;
    out_slot_d  = out_slot_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_mix_d  = '0;
          res_st_d   = psm_pkg::ST_OK;
          res_slot_d = '0;
          idx_d      = '0;
          case (action_i)
            psm_pkg::ACT_LOAD: begin
              mem_we  = 1'b1;
              state_d = S_FINISH;
            end
            psm_pkg::ACT_PLAY: begin
              pstart_d = address_i;
              plen_d   = length_i;
              pgain_d  = gain_i;
              if (length_i == '0) begin
                // empty sound wins over a full pool
                res_st_d = psm_pkg::ST_EMPTY;
                state_d  = S_FINISH;
              end else begin
                state_d = S_SCAN;
              end
            end
            psm_pkg::ACT_STOP: begin
              stop_all = 1'b1;
              state_d  = S_FINISH;
            end
            psm_pkg::ACT_TICK: begin
              mac_ctrl.clr = 1'b1;
              state_d      = S_MIX;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end

      // lowest free voice, one per cycle
      S_SCAN: begin
        if (!vactive_q[vidx]) begin
          claim      = 1'b1;
          res_slot_d = slot_ext[psm_pkg::SLOT_W-1:0];
          state_d    = S_FINISH;
        end else if (last_voice) begin
          res_st_d = psm_pkg::ST_NO_VOICE;
          state_d  = S_FINISH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // one voice per cycle into the read/multiply pipeline
      S_MIX: begin
        if (vactive_q[vidx]) begin
          if (vpos_q[vidx] >= vlen_q[vidx]) begin
            retire = 1'b1;
          end else begin
            issue      = 1'b1;
            s1_valid_d = 1'b1;
          end
        end
        idx_d = idx_q + 1'b1;
        if (last_voice) begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        if (!s1_valid_q && !mac_busy) begin
          res_mix_d = sat_mix;
          state_d   = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_mix_d   = res_mix_q;
          out_st_d    = res_st_q;
          out_slot_d  = res_slot_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    mac_ctrl.vld = s1_valid_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vactive_q   <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (stop_all) begin
        vactive_q <= '0;
      end else if (claim) begin
        vactive_q[vidx] <= 1'b1;
      end else if (retire) begin
        vactive_q[vidx] <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pstart_q   <= pstart_d;
    plen_q     <= plen_d;
    pgain_q    <= pgain_d;
    s1_gain_q  <= s1_gain_d;
    res_mix_q  <= res_mix_d;
    res_st_q   <= res_st_d;
    res_slot_q <= res_slot_d;
    out_mix_q  <= out_mix_d;
    out_st_q   <= out_st_d;
    out_slot_q <= out_slot_d;
    if (claim) begin
      vstart_q[vidx] <= pstart_q;
      vlen_q[vidx]   <= plen_q;
      vpos_q[vidx]   <= '0;
      vgain_q[vidx]  <= pgain_q;
    end else if (issue) begin
      vpos_q[vidx] <= vpos_q[vidx] + 1'b1;
    end
  end

  // Sample memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= sample_value_i;
    end
    if (issue) begin
      rd_data_q <= mem_q[raddr];
    end
  end

  psm_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .sample_i(rd_data_q),
    .gain_i  (s1_gain_q),
    .acc_o   (acc),
    .busy_o  (mac_busy)
  );

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = out_mix_q;
  assign status_o       = out_st_q;
  assign voice_slot_o   = out_slot_q;

endmodule

`default_nettype wire

// ===== sv/psm_mac.sv =====
// Shared multiply-accumulate unit: scales one sample by a Q2.14 gain,
// truncates toward zero and adds into the mix accumulator. Uses psm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psm_mac #(
  parameter int ACC_W = 22
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire psm_pkg::mac_ctrl_t                   ctrl_i,
  input  wire logic signed [psm_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire logic        [psm_pkg::GAIN_W-1:0]    gain_i,
  output logic signed [ACC_W-1:0]                   acc_o,
  output logic                                      busy_o
);

  logic signed [psm_pkg::PROD_W-1:0] prod_q, prod_d;
  logic                              pvld_q;
  logic signed [ACC_W-1:0]           acc_q, acc_d;
  logic signed [psm_pkg::PROD_W-1:0] biased;
  logic signed [psm_pkg::TERM_W-1:0] term;

  // Stage one: the multiply
  assign prod_d = sample_i * $signed({1'b0, gain_i});

  // Stage two: round toward zero, then accumulate
  always_comb begin
    biased = prod_q;
    if (prod_q[psm_pkg::PROD_W-1]) begin
      biased = prod_q + psm_pkg::PROD_W'((1 << psm_pkg::GAIN_SHIFT) - 1);
    end
    term = biased[psm_pkg::GAIN_SHIFT+psm_pkg::TERM_W-1:psm_pkg::GAIN_SHIFT];
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (pvld_q) begin
      acc_d = acc_q + ACC_W'(term);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = pvld_q;

endmodule

`default_nettype wire

// ===== tb/polyphonic_sample_mixer_test.sv =====
// Self-checking testbench for polyphonic_sample_mixer: directed and random transactions
// are checked against an in-bench voice/memory predictor held in a small scoreboard.
// Depends on psm_pkg and the polyphonic_sample_mixer RTL.
`timescale 1ns / 1ps

module polyphonic_sample_mixer_test;
  import psm_pkg::*;

  localparam int NUM_VOICES  = VOICES_DEF;
  localparam int MEM_WORDS   = MEM_DEPTH_DEF;
  localparam int ITEM_TARGET = 1180;    // directed part plus about 1150 random
  localparam int CYCLE_LIMIT = 600000;  // several times the slowest legal run
  localparam int DRAIN_WAIT  = 40;      // comfortably beyond one tick
  localparam int HOLD_AT     = 300;     // transactions accepted before the long stall
  localparam int HOLD_CYCLES = 600;

  // One result transaction as the block presents it
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed;
    logic [STAT_W-1:0]          status;
    logic [SLOT_W-1:0]          slot;
  } mix_result_t;

  // Predictor of the voice pool and sample memory, plus the queue of
  // results still owed by the block.
  class mixer_scoreboard;
    logic signed [SAMPLE_W-1:0] sample_store [MEM_WORDS];
    bit                         word_loaded  [MEM_WORDS];
    bit                         voice_busy   [NUM_VOICES];
    logic [ADDR_W-1:0]          voice_base   [NUM_VOICES];
    logic [LEN_W-1:0]           voice_len    [NUM_VOICES];
    logic [LEN_W-1:0]           voice_pos    [NUM_VOICES];
    logic [GAIN_W-1:0]          voice_gain   [NUM_VOICES];
    mix_result_t                owed_results [$];
    int unsigned                accepted;
    int unsigned                errors;

    // One output frame: every live voice adds sample * gain / 2^14
    // (truncated toward zero) and steps on; spent voices are released.
    function logic signed [SAMPLE_W-1:0] mix_frame();
      int                 sum;
      longint             term;
      logic [ADDR_W-1:0]  rd;
      sum = 0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        if (!voice_busy[v]) continue;
        if (voice_pos[v] >= voice_len[v]) begin
          voice_busy[v] = 1'b0;
          continue;
        end
        rd   = voice_base[v] + voice_pos[v][ADDR_W-1:0];
        term = (longint'(sample_store[rd]) * longint'(voice_gain[v])) /
               (longint'(1) << GAIN_SHIFT);
        sum += int'(term);
        voice_pos[v] = voice_pos[v] + 1'b1;
      end
      if (sum > SAT_MAX) return SAMPLE_W'(SAT_MAX);
      if (sum < SAT_MIN) return SAMPLE_W'(SAT_MIN);
      return SAMPLE_W'(sum);
    endfunction

    function void note_transaction(logic [ACT_W-1:0] action, logic [ADDR_W-1:0] address,
                                   logic signed [SAMPLE_W-1:0] value,
                                   logic [LEN_W-1:0] length, logic [GAIN_W-1:0] gain);
      mix_result_t r;
      int          found;
      r     = '0;
      found = -1;
      accepted++;
      case (action)
        ACT_LOAD: begin
          sample_store[address] = value;
          word_loaded[address]  = 1'b1;
        end
        ACT_PLAY: begin
          if (length == '0) begin
            r.status = ST_EMPTY;
          end else begin
            for (int v = 0; v < NUM_VOICES; v++) begin
              if (!voice_busy[v]) begin
                found = v;
                break;
              end
            end
            if (found < 0) begin
              r.status = ST_NO_VOICE;
            end else begin
              voice_busy[found] = 1'b1;
              voice_base[found] = address;
              voice_len[found]  = length;
              voice_pos[found]  = '0;
              voice_gain[found] = gain;
              r.slot            = SLOT_W'(found);
            end
          end
        end
        ACT_STOP: begin
          foreach (voice_busy[v]) voice_busy[v] = 1'b0;
        end
        default: begin
          r.mixed = mix_frame();
        end
      endcase
      owed_results.push_back(r);
    endfunction

    function void log_mismatch(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] mixed, logic [STAT_W-1:0] status,
                               logic [SLOT_W-1:0] slot);
      mix_result_t want;
      if (owed_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result: mixed %0d status %0d slot %0d",
                               mixed, status, slot));
      end else begin
        want = owed_results.pop_front();
        if (want.mixed !== mixed || want.status !== status || want.slot !== slot)
          log_mismatch($sformatf({"mismatch: mixed exp %0d got %0d, status exp %0d got %0d,",
                                  " slot exp %0d got %0d"}, want.mixed, mixed,
                                 want.status, status, want.slot, slot));
      end
    endfunction

    // Next word some live voice will read on a tick, if it was never loaded
    function bit find_unwritten_read(output logic [ADDR_W-1:0] addr);
      addr = '0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        if (voice_busy[v] && voice_pos[v] < voice_len[v]) begin
          addr = voice_base[v] + voice_pos[v][ADDR_W-1:0];
          if (!word_loaded[addr]) return 1'b1;
        end
      end
      return 1'b0;
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [ACT_W-1:0]            action_i;
  logic [ADDR_W-1:0]           address_i;
  logic signed [SAMPLE_W-1:0]  sample_value_i;
  logic [LEN_W-1:0]            length_i;
  logic [GAIN_W-1:0]           gain_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic signed [SAMPLE_W-1:0]  mixed_sample_o;
  logic [STAT_W-1:0]           status_o;
  logic [SLOT_W-1:0]           voice_slot_o;

  mixer_scoreboard mixer_sb = new();
  int              cycle_count = 0;
  int              burst_left  = 1;
  bit              valid_low   = 1'b1;  // set once the sender has dropped valid

  polyphonic_sample_mixer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .address_i      (address_i),
    .sample_value_i (sample_value_i),
    .length_i       (length_i),
    .gain_i         (gain_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mixed_sample_o (mixed_sample_o),
    .status_o       (status_o),
    .voice_slot_o   (voice_slot_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reset is applied once and never again
  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog: a hang anywhere ends the run as a failure
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("polyphonic_sample_mixer_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side. The payload is driven at the clock edge and held with valid
  // high until the transaction is taken; handshake signals are sampled just
  // after the edge, so they carry their pre-edge values. Bursts of random
  // length are separated by random gaps, and a gap of zero keeps valid high
  // straight into the next transaction.
  // ---------------------------------------------------------------------------
  task automatic send_transaction(logic [ACT_W-1:0] action, logic [ADDR_W-1:0] address,
                                  logic signed [SAMPLE_W-1:0] value,
                                  logic [LEN_W-1:0] length, logic [GAIN_W-1:0] gain);
    int gap;
    in_valid_i     <= 1'b1;
    valid_low       = 1'b0;
    action_i       <= action;
    address_i      <= address;
    sample_value_i <= value;
    length_i       <= length;
    gain_i         <= gain;
    do @(posedge clk_i); while (!in_ready_o);
    mixer_sb.note_transaction(action, address, value, length, gain);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        valid_low   = 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      // now and then a long run with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Unused fields carry random noise on every action
  task automatic send_load(logic [ADDR_W-1:0] address, logic signed [SAMPLE_W-1:0] value);
    send_transaction(ACT_LOAD, address, value, LEN_W'($urandom), GAIN_W'($urandom));
  endtask

  task automatic send_play(logic [ADDR_W-1:0] base, logic [LEN_W-1:0] length,
                           logic [GAIN_W-1:0] gain);
    send_transaction(ACT_PLAY, base, SAMPLE_W'($urandom), length, gain);
  endtask

  task automatic send_stop();
    send_transaction(ACT_STOP, ADDR_W'($urandom), SAMPLE_W'($urandom), LEN_W'($urandom),
                     GAIN_W'($urandom));
  endtask

  // A tick must never read a word that was never loaded: fill any such word
  // a live voice is about to reach before the tick goes out.
  task automatic send_tick();
    logic [ADDR_W-1:0] hole;
    while (mixer_sb.find_unwritten_read(hole)) send_load(hole, SAMPLE_W'($urandom));
    send_transaction(ACT_TICK, ADDR_W'($urandom), SAMPLE_W'($urandom), LEN_W'($urandom),
                     GAIN_W'($urandom));
  endtask

  // Most traffic lands in a small window straddling the top of memory, so
  // sounds reuse loaded words and exercise the address wrap.
  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 9) < 6) return ADDR_W'(16'hffc0 + $urandom_range(0, 127));
    return ADDR_W'($urandom);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)  return '0;
    if (roll < 10) return LEN_W'(MEM_WORDS);
    if (roll < 20) return LEN_W'($urandom_range(1, MEM_WORDS - 1));
    return LEN_W'($urandom_range(1, 48));
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'(1 << GAIN_SHIFT);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [ACT_W-1:0] act;
    in_valid_i     <= 1'b0;
    action_i       <= ACT_LOAD;
    address_i      <= '0;
    sample_value_i <= '0;
    length_i       <= '0;
    gain_i         <= '0;
    do @(posedge clk_i); while (!rst_ni);

    // Directed: idle pool, empty sound, stop with nothing playing
    send_tick();
    send_play(16'h1234, '0, GAIN_W'(1 << GAIN_SHIFT));
    send_stop();
    // extreme samples at both ends of memory
    send_load(16'h0000, 16'sh7fff);
    send_load(16'hffff, 16'sh8000);
    send_load(16'h0001, 16'shffff);
    send_load(16'h0002, 16'sh8000);
    // wrapping sound at full gain, then a one-sample sound at zero gain
    send_play(16'hffff, LEN_W'(3), '1);
    send_play(16'h0000, LEN_W'(1), '0);
    // fill the pool with the longest legal sound at unity gain
    for (int i = 0; i < NUM_VOICES - 2; i++)
      send_play(16'h0000, LEN_W'(MEM_WORDS), GAIN_W'(1 << GAIN_SHIFT));
    send_play(16'h0000, LEN_W'(5), GAIN_W'(1 << GAIN_SHIFT));  // no voice free
    send_play(16'h0000, '0, GAIN_W'(1 << GAIN_SHIFT));         // empty wins over full
    // positive clip; small negative term truncated; negative clip; voice 0 runs out
    repeat (4) send_tick();
    send_play(16'h0001, LEN_W'(2), GAIN_W'(16'h2000));         // lowest free slot reused
    send_stop();
    send_tick();

    // Random: mostly load/play/tick phrases with random content, plus pool
    // exhaustion, stops and fully random noise transactions.
    while (mixer_sb.accepted < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          repeat (NUM_VOICES + 1) send_play(pick_address(), pick_length(), pick_gain());
          repeat ($urandom_range(1, 6)) send_tick();
        end
        2: send_stop();
        3, 4: begin
          repeat ($urandom_range(1, 4)) begin
            act = ACT_W'($urandom_range(0, 3));
            if (act == ACT_TICK) send_tick();
            else send_transaction(act, ADDR_W'($urandom), SAMPLE_W'($urandom),
                                  LEN_W'($urandom_range(0, MEM_WORDS)), GAIN_W'($urandom));
          end
        end
        default: begin
          repeat ($urandom_range(0, 6)) send_load(pick_address(), SAMPLE_W'($urandom));
          repeat ($urandom_range(1, 4)) send_play(pick_address(), pick_length(), pick_gain());
          repeat ($urandom_range(1, 16)) send_tick();
        end
      endcase
    end
    if (!valid_low) in_valid_i <= 1'b0;

    // Drain: every owed result must arrive, then allow time for strays
    while (mixer_sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mixer_sb.errors == 0 && mixer_sb.owed_results.size() == 0) begin
      $display("polyphonic_sample_mixer_test: clean");
    end else begin
      $display("polyphonic_sample_mixer_test: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side. Results are checked at the edge where they are taken.
  // Readiness follows a pattern of its own, picked anew at random intervals:
  // always ready, coin toss, mostly stalled, or a fixed rhythm. Once,
  // after a few hundred transactions, it holds off for a long stretch so that
  // the output register fills and the block stops taking input.
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit hold_done;
    bit take;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i)
        mixer_sb.check_output(mixed_sample_o, status_o, voice_slot_o);
      if (!hold_done && mixer_sb.accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left <= 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (mode)
        0:       take = 1'b1;
        1:       take = $urandom_range(0, 1);
        2:       take = ($urandom_range(0, 4) == 0);
        default: take = (cycle_count % 3 != 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end
      out_ready_i <= take;
    end
  end

endmodule

// ===== files.f =====
sv/psm_pkg.sv
sv/psm_mac.sv
sv/polyphonic_sample_mixer.sv
tb/polyphonic_sample_mixer_test.sv
